/* src/gcc_pkg.sv */
// Shared types, constants and register codes for the grid cell trigger block.
package gcc_pkg;

  localparam int MAX_CELLS = 4096;
  localparam int MAX_SIDE  = 64;
  localparam int CELL_AW   = $clog2(MAX_CELLS);
  localparam int SIDE_W    = $clog2(MAX_SIDE);

  localparam int POS_W   = 12;
  localparam int DIM_W   = 13;
  localparam int GRID_W  = 7;
  localparam int TRAIL_W = 10;
  localparam int TIME_W  = 64;
  localparam int COOL_W  = 48;

  // Product of a coordinate and a grid size, and the quotient bound that
  // follows once the coordinate is known to lie inside the frame.
  localparam int PROD_W = POS_W + GRID_W;
  localparam int QUO_W  = GRID_W;
  localparam int STEP_W = $clog2(QUO_W);
  localparam int IDX_W  = 2 * GRID_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TRAIL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN     = 3'd5;

  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [GRID_W-1:0]  col_count;
    logic [GRID_W-1:0]  row_count;
    logic [TRAIL_W-1:0] min_trail;
    logic [COOL_W-1:0]  cooldown;
  } cfg_t;

  typedef enum logic [1:0] {
    STAT_ACTIVE = 2'd0,
    STAT_SKIP   = 2'd1,
    STAT_COOL   = 2'd2,
    STAT_RANGE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_CELL  = 2'd0,
    KIND_SKIP  = 2'd1,
    KIND_RANGE = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t         kind;
    logic [PROD_W-1:0]  prod_x;
    logic [PROD_W-1:0]  prod_y;
    logic [TIME_W-1:0]  now;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_UPDATE
  } back_state_t;

endpackage

/* src/gcc_front.sv */
// Front end: accepts blob reports, classifies them and forms the scaled products.
module gcc_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gcc_pkg::POS_W-1:0]   pos_x,
  input  logic [gcc_pkg::POS_W-1:0]   pos_y,
  input  logic                        matched,
  input  logic [gcc_pkg::TRAIL_W-1:0] trail_length,
  input  logic [gcc_pkg::TIME_W-1:0]  now,
  input  gcc_pkg::cfg_t               cfg,
  input  logic                        clearing,
  input  logic                        q_full,
  output logic                        push,
  output gcc_pkg::entry_t             push_entry
);
  import gcc_pkg::*;

  logic qualified;
  logic dims_zero;
  logic off_frame;

  assign in_ready = !q_full && !clearing;
  assign push     = in_valid && in_ready;

  assign qualified = matched && (trail_length >= cfg.min_trail);
  assign dims_zero = (cfg.frame_width == '0) || (cfg.frame_height == '0) ||
                     (cfg.col_count == '0) || (cfg.row_count == '0);
  // A coordinate at or past the frame edge always maps to a cell at or past
  // the grid edge, so each axis can be rejected before any division.
  assign off_frame = ({1'b0, pos_x} >= cfg.frame_width) ||
                     ({1'b0, pos_y} >= cfg.frame_height);

  always_comb begin
    push_entry.prod_x = PROD_W'(pos_x) * PROD_W'(cfg.col_count);
    push_entry.prod_y = PROD_W'(pos_y) * PROD_W'(cfg.row_count);
    push_entry.now    = now;
    if (!qualified) begin
      push_entry.kind = KIND_SKIP;
    end else if (dims_zero || off_frame) begin
      push_entry.kind = KIND_RANGE;
    end else begin
      push_entry.kind = KIND_CELL;
    end
  end

endmodule

/* src/gcc_queue.sv */
// Short queue of classified reports between the front and back ends.
module gcc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gcc_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output gcc_pkg::entry_t head
);
  import gcc_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/gcc_back.sv */
// Back end: divides to a cell, checks the deadline store and registers the result.
module gcc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  gcc_pkg::cfg_t              cfg,
  input  logic                       q_valid,
  input  gcc_pkg::entry_t            q_entry,
  output logic                       q_pop,
  output logic                       clearing,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       activated,
  output logic [gcc_pkg::SIDE_W-1:0] cell_col,
  output logic [gcc_pkg::SIDE_W-1:0] cell_row,
  output logic [1:0]                 status
);
  import gcc_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [TIME_W-1:0]  deadline_mem [MAX_CELLS];
  logic [TIME_W-1:0]  mem_rdata;
  logic               mem_we;
  logic               mem_re;
  logic [CELL_AW-1:0] mem_waddr;
  logic [TIME_W-1:0]  mem_wdata;

  logic [CELL_AW-1:0] clr_addr;
  logic [STEP_W-1:0]  step;
  logic [PROD_W-1:0]  rem_x;
  logic [PROD_W-1:0]  rem_y;
  logic [QUO_W-1:0]   quo_x;
  logic [QUO_W-1:0]   quo_y;
  logic [TIME_W-1:0]  now_r;
  logic [CELL_AW-1:0] cell_addr;

  logic [PROD_W:0]    shift_x;
  logic [PROD_W:0]    shift_y;
  logic [PROD_W:0]    diff_x;
  logic [PROD_W:0]    diff_y;
  logic               take_x;
  logic               take_y;
  logic [IDX_W-1:0]   idx;
  logic               in_range;
  logic               res_free;
  logic               cell_free;
  logic [TIME_W-1:0]  new_deadline;

  logic               res_load;
  logic               res_act_d;
  logic [SIDE_W-1:0]  res_col_d;
  logic [SIDE_W-1:0]  res_row_d;
  status_t            res_stat_d;
  logic               res_valid;
  status_t            res_stat;

  // Restoring division, one quotient bit per axis each cycle. The quotient
  // is known to be below the grid size, so only QUO_W steps are needed.
  assign shift_x = (PROD_W + 1)'(cfg.frame_width) << step;
  assign shift_y = (PROD_W + 1)'(cfg.frame_height) << step;
  assign diff_x  = {1'b0, rem_x} - shift_x;
  assign diff_y  = {1'b0, rem_y} - shift_y;
  assign take_x  = !diff_x[PROD_W];
  assign take_y  = !diff_y[PROD_W];

  assign idx = IDX_W'(quo_y) * IDX_W'(cfg.col_count) + IDX_W'(quo_x);
  assign in_range = (32'(quo_x) < MAX_SIDE) && (32'(quo_y) < MAX_SIDE) &&
                    (32'(idx) < MAX_CELLS);

  assign res_free     = !res_valid || out_ready;
  assign cell_free    = (mem_rdata == '0) || (now_r > mem_rdata);
  assign new_deadline = now_r + TIME_W'(cfg.cooldown);

  assign clearing  = (state == ST_CLEAR);
  assign out_valid = res_valid;
  assign status    = 2'(res_stat);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == CELL_AW'(MAX_CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid && res_free && q_entry.kind == KIND_CELL) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step == '0) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = in_range ? ST_UPDATE : ST_IDLE;
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = cell_addr;
    mem_wdata  = new_deadline;
    res_load   = 1'b0;
    res_act_d  = 1'b0;
    res_col_d  = '0;
    res_row_d  = '0;
    res_stat_d = STAT_RANGE;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        q_pop = q_valid && res_free;
        if (q_pop && q_entry.kind != KIND_CELL) begin
          res_load   = 1'b1;
          res_stat_d = (q_entry.kind == KIND_SKIP) ? STAT_SKIP : STAT_RANGE;
        end
      end
      ST_DIV: begin
      end
      ST_CHECK: begin
        mem_re = in_range;
        if (!in_range) begin
          res_load = 1'b1;
        end
      end
      ST_UPDATE: begin
        res_load  = 1'b1;
        res_col_d = quo_x[SIDE_W-1:0];
        res_row_d = quo_y[SIDE_W-1:0];
        if (cell_free) begin
          mem_we     = 1'b1;
          res_act_d  = 1'b1;
          res_stat_d = STAT_ACTIVE;
        end else begin
          res_stat_d = STAT_COOL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      deadline_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= deadline_mem[idx[CELL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + CELL_AW'(1);
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rem_x <= q_entry.prod_x;
      rem_y <= q_entry.prod_y;
      quo_x <= '0;
      quo_y <= '0;
      step  <= STEP_W'(QUO_W - 1);
      now_r <= q_entry.now;
    end else if (state == ST_DIV) begin
      rem_x <= take_x ? diff_x[PROD_W-1:0] : rem_x;
      rem_y <= take_y ? diff_y[PROD_W-1:0] : rem_y;
      quo_x <= {quo_x[QUO_W-2:0], take_x};
      quo_y <= {quo_y[QUO_W-2:0], take_y};
      step  <= step - STEP_W'(1);
    end
    if (state == ST_CHECK) begin
      cell_addr <= idx[CELL_AW-1:0];
    end
    if (res_load) begin
      activated <= res_act_d;
      cell_col  <= res_col_d;
      cell_row  <= res_row_d;
      res_stat  <= res_stat_d;
    end
  end

endmodule

/* src/grid_cell_trigger_cooldown.sv */
// Grid cell trigger with per-cell cooldown: configuration registers and top-level wiring.
// After reset the block clears its deadline store, one cell per cycle, and accepts no
// report during that time (configuration writes are taken). A report that is skipped
// or rejected before division is popped and its result registered once the output
// register is free; a report that reaches the grid goes through a start state, the
// shift-subtract dividers that find column and row, a check of the cell that reads its
// deadline (a cell outside the store leaves here), and a compare that may write it back.
// A two-entry queue lets new reports be accepted while a result waits to be taken.
module grid_cell_trigger_cooldown (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gcc_pkg::POS_W-1:0]      pos_x,
  input  logic [gcc_pkg::POS_W-1:0]      pos_y,
  input  logic                           matched,
  input  logic [gcc_pkg::TRAIL_W-1:0]    trail_length,
  input  logic [gcc_pkg::TIME_W-1:0]     now,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           activated,
  output logic [gcc_pkg::SIDE_W-1:0]     cell_col,
  output logic [gcc_pkg::SIDE_W-1:0]     cell_row,
  output logic [1:0]                     status
);
  import gcc_pkg::*;

  cfg_t   cfg;
  logic   clearing;
  logic   q_full;
  logic   push;
  entry_t push_entry;
  logic   q_pop;
  logic   q_valid;
  entry_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= DIM_W'(640);
      cfg.frame_height <= DIM_W'(480);
      cfg.col_count    <= GRID_W'(8);
      cfg.row_count    <= GRID_W'(8);
      cfg.min_trail    <= TRAIL_W'(10);
      cfg.cooldown     <= COOL_W'(64'd3000000000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[DIM_W-1:0];
        REG_GRID_COLS:    cfg.col_count    <= cfg_data[GRID_W-1:0];
        REG_GRID_ROWS:    cfg.row_count    <= cfg_data[GRID_W-1:0];
        REG_MIN_TRAIL:    cfg.min_trail    <= cfg_data[TRAIL_W-1:0];
        REG_COOLDOWN:     cfg.cooldown     <= cfg_data[COOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gcc_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .matched      (matched),
    .trail_length (trail_length),
    .now          (now),
    .cfg          (cfg),
    .clearing     (clearing),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  gcc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  gcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .activated (activated),
    .cell_col  (cell_col),
    .cell_row  (cell_row),
    .status    (status)
  );

endmodule
